FILE: sv/jsd_pkg.sv
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared constants, types and the logarithm table for the divergence
// accumulator.
// ----------------------------------------------------------------------------
package jsd_pkg;

   localparam int PROB_FRAC_BITS = 16;
   localparam int LOG_TABLE_BITS = 8;
   localparam int SUM_BITS       = 48;
   localparam int LOG_FRAC       = 16;
   localparam int OUT_BITS       = 32;

   localparam int PROB_BITS  = PROB_FRAC_BITS + 1;   // 1.0 itself must fit
   localparam int PSUM_BITS  = PROB_BITS + 1;        // p + q
   localparam int EXP_BITS   = $clog2(PSUM_BITS);
   localparam int LG_BITS    = EXP_BITS + LOG_FRAC;
   localparam int DIFF_BITS  = LG_BITS + 2;
   localparam int PROD_BITS  = PROB_BITS + 1 + DIFF_BITS;
   localparam int TERM_BITS  = PROD_BITS + 1;
   localparam int WIDE_BITS  = ((SUM_BITS > TERM_BITS) ? SUM_BITS : TERM_BITS) + 1;
   localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;

   localparam int REQ_DATA_BITS = ((2 * PROB_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = OUT_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      MODE_KL = 1'b0,
      MODE_JS = 1'b1
   } mode_type;

   // one classified pair, as handed from the front end to the back end
   typedef struct packed {
      mode_type                      mode;
      logic                          last;
      logic                          use_p;
      logic                          use_q;
      logic [PROB_BITS-1:0]          p;
      logic [PROB_BITS-1:0]          q;
      logic signed [DIFF_BITS-1:0]   dp;
      logic signed [DIFF_BITS-1:0]   dq;
   } jsd_item_type;

   typedef logic [LOG_FRAC-1:0] log_rom_type [TABLE_SIZE];

   // fractional part of log2(1 + k/TABLE_SIZE) by repeated squaring
   function automatic log_rom_type build_log_rom();
      log_rom_type         rom;
      logic [63:0]         z;
      logic [LOG_FRAC-1:0] r;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         z = 64'(TABLE_SIZE + k) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int i = 0; i < LOG_FRAC; i++) begin
            z = (z * z) >> 30;
            r = r << 1;
            if (z >= (64'd1 << 31)) begin
               r[0] = 1'b1;
               z = z >> 1;
            end
         end
         rom[k] = r;
      end
      return rom;
   endfunction

endpackage

FILE: sv/jsd_front.sv
// ----------------------------------------------------------------------------
// jsd_front
// Accept a pair, classify it and form the log2 differences that weight it.
// ----------------------------------------------------------------------------
module jsd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  jsd_pkg::mode_type               mode,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [jsd_pkg::PROB_BITS-1:0]   in_p,
   input  logic [jsd_pkg::PROB_BITS-1:0]   in_q,
   input  logic                            in_last,
   output logic                            out_valid,
   input  logic                            out_ready,
   output jsd_pkg::jsd_item_type           out_item
);
   import jsd_pkg::*;

   localparam log_rom_type LOG_ROM = build_log_rom();

   function automatic logic [EXP_BITS-1:0] lead_one(input logic [PSUM_BITS-1:0] x);
      logic [EXP_BITS-1:0] e;
      e = '0;
      for (int i = 0; i < PSUM_BITS; i++) begin
         if (x[i]) e = EXP_BITS'(i);
      end
      return e;
   endfunction

   // integer part from the leading one, fraction from the bits just below it
   function automatic logic [LG_BITS-1:0] lg_of(input logic [PSUM_BITS-1:0] x,
                                                input logic [EXP_BITS-1:0]  e);
      logic [PSUM_BITS+LOG_TABLE_BITS-1:0] ext;
      logic [LOG_TABLE_BITS-1:0]           k;
      ext = {x, {LOG_TABLE_BITS{1'b0}}};
      k   = LOG_TABLE_BITS'(ext >> e);
      return {e, LOG_ROM[k]};
   endfunction

   // stage 1: operands and exponents
   logic                  s1_valid_ff, s1_valid_in;
   mode_type              s1_mode_ff,  s1_mode_in;
   logic                  s1_last_ff,  s1_last_in;
   logic [PSUM_BITS-1:0]  s1_p_ff,     s1_p_in;
   logic [PSUM_BITS-1:0]  s1_q_ff,     s1_q_in;
   logic [PSUM_BITS-1:0]  s1_s_ff,     s1_s_in;
   logic [EXP_BITS-1:0]   s1_ep_ff,    s1_ep_in;
   logic [EXP_BITS-1:0]   s1_eq_ff,    s1_eq_in;
   logic [EXP_BITS-1:0]   s1_es_ff,    s1_es_in;

   // stage 2: finished item
   logic                  s2_valid_ff, s2_valid_in;
   jsd_item_type          item_ff,     item_in;

   logic                  s1_ready, s2_ready;
   logic [PSUM_BITS-1:0]  p_ext, q_ext, s_ext;
   logic [LG_BITS-1:0]    lg_p, lg_q, lg_s;
   logic signed [DIFF_BITS-1:0] lgs_p, lgs_q, lgs_s;
   logic                  p_nz, q_nz;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign p_ext = {1'b0, in_p};
   assign q_ext = {1'b0, in_q};
   assign s_ext = p_ext + q_ext;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_mode_in  = s1_mode_ff;
      s1_last_in  = s1_last_ff;
      s1_p_in     = s1_p_ff;
      s1_q_in     = s1_q_ff;
      s1_s_in     = s1_s_ff;
      s1_ep_in    = s1_ep_ff;
      s1_eq_in    = s1_eq_ff;
      s1_es_in    = s1_es_ff;
      if (s1_ready) begin
         s1_valid_in = in_valid;
         s1_mode_in  = mode;
         s1_last_in  = in_last;
         s1_p_in     = p_ext;
         s1_q_in     = q_ext;
         s1_s_in     = s_ext;
         s1_ep_in    = lead_one(p_ext);
         s1_eq_in    = lead_one(q_ext);
         s1_es_in    = lead_one(s_ext);
      end
   end

   always_comb begin
      lg_p  = lg_of(s1_p_ff, s1_ep_ff);
      lg_q  = lg_of(s1_q_ff, s1_eq_ff);
      lg_s  = lg_of(s1_s_ff, s1_es_ff);
      lgs_p = $signed({2'b00, lg_p});
      lgs_q = $signed({2'b00, lg_q});
      lgs_s = $signed({2'b00, lg_s});
      p_nz  = (s1_p_ff != '0);
      q_nz  = (s1_q_ff != '0);

      item_in      = item_ff;
      s2_valid_in  = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in  = s1_valid_ff;
         item_in.mode = s1_mode_ff;
         item_in.last = s1_last_ff;
         item_in.p    = PROB_BITS'(s1_p_ff);
         item_in.q    = PROB_BITS'(s1_q_ff);
         unique case (s1_mode_ff)
            MODE_KL: begin
               item_in.use_p = p_nz && q_nz;
               item_in.use_q = 1'b0;
               item_in.dp    = lgs_p - lgs_q;
               item_in.dq    = '0;
            end
            MODE_JS: begin
               // log2(x/r) with r = (p+q)/2
               item_in.use_p = p_nz;
               item_in.use_q = q_nz;
               item_in.dp    = lgs_p - lgs_s + DIFF_BITS'(1 << LOG_FRAC);
               item_in.dq    = lgs_q - lgs_s + DIFF_BITS'(1 << LOG_FRAC);
            end
            default: begin
               item_in.use_p = 1'b0;
               item_in.use_q = 1'b0;
               item_in.dp    = '0;
               item_in.dq    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff <= s1_mode_in;
      s1_last_ff <= s1_last_in;
      s1_p_ff    <= s1_p_in;
      s1_q_ff    <= s1_q_in;
      s1_s_ff    <= s1_s_in;
      s1_ep_ff   <= s1_ep_in;
      s1_eq_ff   <= s1_eq_in;
      s1_es_ff   <= s1_es_in;
      item_ff    <= item_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: sv/jsd_queue.sv
// ----------------------------------------------------------------------------
// jsd_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module jsd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  jsd_pkg::jsd_item_type   in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output jsd_pkg::jsd_item_type   out_item
);
   import jsd_pkg::*;

   jsd_item_type           mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff,  count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= in_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push without pop did not grow the count");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with mismatched pointers");

endmodule

FILE: sv/jsd_back.sv
// ----------------------------------------------------------------------------
// jsd_back
// Weight the log differences, accumulate the terms with saturation and
// present the sum at the end of each run.
// ----------------------------------------------------------------------------
module jsd_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  jsd_pkg::jsd_item_type                   in_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [jsd_pkg::OUT_BITS-1:0]     rsp_divergence,
   output logic                                    rsp_saturated
);
   import jsd_pkg::*;

   localparam logic signed [WIDE_BITS-1:0] SUM_MAX =
      {{(WIDE_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] SUM_MIN = ~SUM_MAX;
   localparam logic signed [SUM_BITS-1:0]  OUT_MAX =
      {{(SUM_BITS-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0]  OUT_MIN = ~OUT_MAX;
   localparam logic [TERM_BITS-1:0] BIAS_KL = TERM_BITS'((1 << PROB_FRAC_BITS) - 1);
   localparam logic [TERM_BITS-1:0] BIAS_JS = TERM_BITS'((1 << (PROB_FRAC_BITS + 1)) - 1);

   // multiply stage
   logic                          m_valid_ff, m_valid_in;
   mode_type                      m_mode_ff,  m_mode_in;
   logic                          m_last_ff,  m_last_in;
   logic signed [PROD_BITS-1:0]   prod_p_ff,  prod_p_in;
   logic signed [PROD_BITS-1:0]   prod_q_ff,  prod_q_in;

   // term stage
   logic                          t_valid_ff, t_valid_in;
   logic                          t_last_ff,  t_last_in;
   logic signed [TERM_BITS-1:0]   term_ff,    term_in;

   // accumulator and result register
   logic signed [SUM_BITS-1:0]    sum_ff,     sum_in;
   logic                          ovf_ff,     ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]    div_ff,     div_in;
   logic                          sat_ff,     sat_in;

   logic                          acc_ready, acc_fire, t_ready, m_ready;
   logic signed [TERM_BITS-1:0]   pair_sum, biased;
   logic signed [WIDE_BITS-1:0]   wide;
   logic signed [SUM_BITS-1:0]    sum_new;
   logic                          ovf_new;

   assign acc_ready = !rsp_valid_ff || rsp_ready;
   assign acc_fire  = t_valid_ff && acc_ready;
   assign t_ready   = !t_valid_ff || acc_ready;
   assign m_ready   = !m_valid_ff || t_ready;
   assign in_ready  = m_ready;

   // multiply
   always_comb begin
      m_valid_in = m_valid_ff;
      m_mode_in  = m_mode_ff;
      m_last_in  = m_last_ff;
      prod_p_in  = prod_p_ff;
      prod_q_in  = prod_q_ff;
      if (m_ready) begin
         m_valid_in = in_valid;
         m_mode_in  = in_item.mode;
         m_last_in  = in_item.last;
         prod_p_in  = '0;
         prod_q_in  = '0;
         if (in_item.use_p) begin
            prod_p_in = $signed({1'b0, in_item.p}) * $signed(in_item.dp);
         end
         if (in_item.use_q) begin
            prod_q_in = $signed({1'b0, in_item.q}) * $signed(in_item.dq);
         end
      end
   end

   // scale back, rounding toward zero
   always_comb begin
      pair_sum = TERM_BITS'(prod_p_ff) + TERM_BITS'(prod_q_ff);
      biased   = pair_sum;
      if (pair_sum < 0) begin
         biased = pair_sum + $signed((m_mode_ff == MODE_JS) ? BIAS_JS : BIAS_KL);
      end
      t_valid_in = t_valid_ff;
      t_last_in  = t_last_ff;
      term_in    = term_ff;
      if (t_ready) begin
         t_valid_in = m_valid_ff;
         t_last_in  = m_last_ff;
         term_in    = (m_mode_ff == MODE_JS) ? (biased >>> (PROB_FRAC_BITS + 1))
                                             : (biased >>> PROB_FRAC_BITS);
      end
   end

   // saturating accumulate
   always_comb begin
      wide    = WIDE_BITS'(sum_ff) + WIDE_BITS'(term_ff);
      sum_new = SUM_BITS'(wide);
      ovf_new = ovf_ff;
      if (wide > SUM_MAX) begin
         sum_new = SUM_BITS'(SUM_MAX);
         ovf_new = 1'b1;
      end else if (wide < SUM_MIN) begin
         sum_new = SUM_BITS'(SUM_MIN);
         ovf_new = 1'b1;
      end

      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      div_in       = div_ff;
      sat_in       = sat_ff;
      if (acc_fire) begin
         sum_in = sum_new;
         ovf_in = ovf_new;
         if (t_last_ff) begin
            sum_in       = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            sat_in       = ovf_new;
            priority if (sum_new > OUT_MAX) begin
               div_in = OUT_BITS'(OUT_MAX);
               sat_in = 1'b1;
            end else if (sum_new < OUT_MIN) begin
               div_in = OUT_BITS'(OUT_MIN);
               sat_in = 1'b1;
            end else begin
               div_in = OUT_BITS'(sum_new);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         t_valid_ff   <= t_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      m_mode_ff <= m_mode_in;
      m_last_ff <= m_last_in;
      prod_p_ff <= prod_p_in;
      prod_q_ff <= prod_q_in;
      t_last_ff <= t_last_in;
      term_ff   <= term_in;
      div_ff    <= div_in;
      sat_ff    <= sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_divergence = div_ff;
   assign rsp_saturated  = sat_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      acc_fire && t_last_ff |=> sum_ff == '0 && !ovf_ff)
      else $error("sum not cleared after end of run");

   a_last_shows: assert property (@(posedge clock) disable iff (reset)
      acc_fire && t_last_ff |=> rsp_valid_ff)
      else $error("end of run produced no result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(acc_fire && t_last_ff))
      else $error("result appeared without an end of run");

endmodule

FILE: sv/jensen_shannon_divergence.sv
// ----------------------------------------------------------------------------
// jensen_shannon_divergence
// Accumulate Kullback-Leibler or Jensen-Shannon divergence, in bits, over
// runs of paired probabilities and emit one signed Q16.16 sum per run.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Moves                   Payload
//  req_     in         one probability pair    tdata[16:0] p_value,
//                                              tdata[33:17] q_value, tlast
//  rsp_     out        one divergence per run  tdata[31:0] divergence,
//                                              tuser saturated
//  csr_     in         mode register write     wr_data: 0 = KL, 1 = JS
//
//  One transaction is taken per cycle when nothing stalls; the rate is set by
//  the accumulator, which adds one term a cycle. A run's last pair passes
//  through the two front stages, the queue, multiply, scale and accumulate
//  before its result appears. Reset is synchronous; it empties every stage,
//  clears the sum and sets the mode to Jensen-Shannon. A stalled rsp_ holds
//  the back end only; the four-entry queue lets the front keep taking pairs
//  until it fills.
//
module jensen_shannon_divergence (
   input  logic                                  clock,
   input  logic                                  reset,
   // input pairs
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [16:0] p_value, [33:17] q_value, rest zero
   input  logic [jsd_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                  req_tlast,
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] divergence
   output logic [jsd_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // [0] saturated
   output logic                                  rsp_tuser,
   // mode register
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data
);
   import jsd_pkg::*;

   // mode register: sampled with every pair, so each pair keeps its own mode
   mode_type       mode_ff, mode_in;

   jsd_item_type   front_item, back_item;
   logic           front_valid, front_ready;
   logic           back_valid,  back_ready;
   logic signed [OUT_BITS-1:0] divergence;

   assign mode_in = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_JS;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // classify pairs and look up their logarithms
   jsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_p      (req_tdata[PROB_BITS-1:0]),
      .in_q      (req_tdata[2*PROB_BITS-1:PROB_BITS]),
      .in_last   (req_tlast),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // decouple the two halves so either may stall alone
   jsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   // weight, accumulate and present the run's sum
   jsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (back_valid),
      .in_ready       (back_ready),
      .in_item        (back_item),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_divergence (divergence),
      .rsp_saturated  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_BITS'(divergence);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the divergence accumulator. Pairs are offered on
// req_, run sums are taken from rsp_, and every sum is compared with a
// bit-exact software copy of the fixed-point arithmetic. A short table of hand
// cases comes first, then random runs in both modes under three idling mixes,
// a long result hold-off, and a long run that drives the output into clamping.
// ----------------------------------------------------------------------------
module tb;
   import jsd_pkg::*;

   localparam int     CYCLE_LIMIT  = 1000000;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     DRAIN_CYCLES = 24;
   localparam longint SUM_HI       = (longint'(1) <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_LO       = -SUM_HI - 1;
   localparam longint OUT_HI       = (longint'(1) <<< (OUT_BITS - 1)) - 1;
   localparam longint OUT_LO       = -(longint'(1) <<< (OUT_BITS - 1));

   typedef struct {
      logic [31:0] divergence;
      logic        saturated;
   } run_sum_type;

   // one directed row: either a mode write or one offered pair
   typedef struct packed {
      logic        wr_mode;
      mode_type    mode;
      logic [16:0] p;
      logic [16:0] q;
      logic        last;
      logic        typed;      // expected sum given below, not predicted
      logic [31:0] div;
      logic        sat;
   } stim_row_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     req_tlast   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_wr_en   = 1'b0;
   logic                     csr_wr_data = 1'b0;

   // bench state
   run_sum_type pending_sums [$];
   mode_type active_mode   = MODE_JS;
   longint   run_sum       = 0;
   logic     run_clamped   = 1'b0;
   int       send_idle_pct = 0;
   int       rsp_idle_pct  = 0;
   logic     hold_go       = 1'b0;
   logic     rsp_hold      = 1'b0;
   int       error_count   = 0;
   int       cycle_count   = 0;
   int       pairs_sent    = 0;
   int       sums_checked  = 0;
   int       sums_clamped  = 0;

   stim_row_type directed_rows [0:23] = '{
      // straight after reset the block is in Jensen-Shannon mode
      '{1'b0, MODE_JS, 17'd0,      17'd0,      1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd65536,  17'd65536,  1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd65536,  17'd0,      1'b1, 1'b1, 32'h0000_8000, 1'b0},
      '{1'b0, MODE_JS, 17'd0,      17'd65536,  1'b1, 1'b1, 32'h0000_8000, 1'b0},
      '{1'b0, MODE_JS, 17'd131071, 17'd131071, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      // disjoint supports: half a bit from each side
      '{1'b0, MODE_JS, 17'd65536,  17'd0,      1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd0,      17'd65536,  1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd1,      17'd131071, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd131071, 17'd1,      1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd20000,  17'd45000,  1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_JS, 17'd45536,  17'd19535,  1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, MODE_KL, 17'd0,      17'd0,      1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd65536,  17'd65536,  1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd65536,  17'd32768,  1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd32768,  17'd65536,  1'b1, 1'b1, 32'hFFFF_8000, 1'b0},
      // a zero on either side adds nothing
      '{1'b0, MODE_KL, 17'd0,      17'd65536,  1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd65536,  17'd0,      1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd0,      17'd0,      1'b1, 1'b1, 32'h0000_0000, 1'b0},
      // a negative term truncates toward zero
      '{1'b0, MODE_KL, 17'd1,      17'd131071, 1'b1, 1'b1, 32'hFFFF_FFF0, 1'b0},
      '{1'b0, MODE_KL, 17'd131071, 17'd1,      1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd1,      17'd1,      1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd30000,  17'd50000,  1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, MODE_KL, 17'd100000, 17'd7,      1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, MODE_JS, 17'd0,      17'd0,      1'b0, 1'b0, 32'h0000_0000, 1'b0}
   };

   jensen_shannon_divergence DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // log2 in Q.16: position of the leading one plus a table fraction
   // rebuilt here by repeated squaring of the mantissa
   function automatic longint log2_q16(input logic [17:0] x);
      int                  msb;
      logic [63:0]         y;
      logic [63:0]         z;
      logic [LOG_FRAC-1:0] frac;
      msb = 0;
      for (int b = 0; b < 18; b++)
         if (x[b]) msb = b;
      y    = 64'(x) << (31 - msb);
      z    = (y >> (31 - LOG_TABLE_BITS)) & ((64'd1 << LOG_TABLE_BITS) - 1);
      z    = (64'd1 << 30) | (z << (30 - LOG_TABLE_BITS));
      frac = '0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         z    = (z * z) >> 30;
         frac = frac << 1;
         if (z >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            z       = z >> 1;
         end
      end
      return (longint'(msb) <<< LOG_FRAC) + longint'(frac);
   endfunction

   function automatic longint shift_toward_zero(input longint v, input int s);
      if (v < 0)
         return -((-v) >> s);
      return v >> s;
   endfunction

   function automatic longint divergence_term(input mode_type m, input logic [16:0] p,
                                              input logic [16:0] q);
      longint mix;
      longint acc;
      acc = 0;
      if (m == MODE_KL) begin
         if (p != 0 && q != 0)
            acc = longint'(p) * (log2_q16({1'b0, p}) - log2_q16({1'b0, q}));
         return shift_toward_zero(acc, PROB_FRAC_BITS);
      end
      // log2 of the midpoint r = (p + q) / 2
      mix = log2_q16({1'b0, p} + {1'b0, q}) - (longint'(1) <<< LOG_FRAC);
      if (p != 0)
         acc += longint'(p) * (log2_q16({1'b0, p}) - mix);
      if (q != 0)
         acc += longint'(q) * (log2_q16({1'b0, q}) - mix);
      return shift_toward_zero(acc, PROB_FRAC_BITS + 1);
   endfunction

   // fold one accepted pair into the running sum; queue the run sum on last
   task automatic accumulate_pair(input logic [16:0] p, input logic [16:0] q,
                                  input logic last, input logic typed,
                                  input logic [31:0] typed_div, input logic typed_sat);
      longint      term;
      longint      v;
      run_sum_type r;
      term = divergence_term(active_mode, p, q);
      if (term > 0 && run_sum > SUM_HI - term) begin
         run_sum     = SUM_HI;
         run_clamped = 1'b1;
      end else if (term < 0 && run_sum < SUM_LO - term) begin
         run_sum     = SUM_LO;
         run_clamped = 1'b1;
      end else begin
         run_sum += term;
      end
      if (last) begin
         v           = run_sum;
         r.saturated = run_clamped;
         if (v > OUT_HI) begin
            v           = OUT_HI;
            r.saturated = 1'b1;
         end else if (v < OUT_LO) begin
            v           = OUT_LO;
            r.saturated = 1'b1;
         end
         r.divergence = v[31:0];
         if (typed) begin
            r.divergence = typed_div;
            r.saturated  = typed_sat;
         end
         pending_sums.push_back(r);
         run_sum     = 0;
         run_clamped = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic offer_pair(input logic [16:0] p, input logic [16:0] q, input logic last,
                             input logic typed, input logic [31:0] typed_div,
                             input logic typed_sat);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({q, p});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
      accumulate_pair(p, q, last, typed, typed_div, typed_sat);
   endtask

   // only with the pipeline empty: drain the sums, then let stragglers settle
   task automatic write_mode(input mode_type m);
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_mode = m;
   endtask

   function automatic logic [16:0] pick_prob();
      case ($urandom_range(0, 9))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'($urandom_range(1, 15));
         3:       return 17'($urandom_range(65537, 131071));
         4:       return ($urandom_range(0, 3) == 0) ? 17'd131071
                                                     : 17'($urandom_range(0, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic random_runs(input int n_items);
      int          sent;
      int          len;
      logic [16:0] p;
      logic [16:0] q;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            p = pick_prob();
            q = ($urandom_range(0, 7) == 0) ? p : pick_prob();
            offer_pair(p, q, i == len - 1, 1'b0, '0, 1'b0);
         end
         sent += len;
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // slow sender, very slow receiver
      send_idle_pct = 18;
      rsp_idle_pct <= 66;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].wr_mode)
            write_mode(directed_rows[i].mode);
         else
            offer_pair(directed_rows[i].p, directed_rows[i].q, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].div, directed_rows[i].sat);
      end

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 66;
            rsp_idle_pct <= 18;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         for (int blk = 0; blk < 5; blk++) begin
            write_mode((blk % 2 == 1) ? MODE_JS : MODE_KL);
            random_runs(40);
         end
      end

      // hold rsp_ off for a long stretch and keep offering: the queue fills
      write_mode(MODE_JS);
      hold_go <= 1'b1;
      random_runs(80);

      // heavy p against q of one adds about 34 bits a pair: push the sum
      // past the top of Q16.16
      write_mode(MODE_KL);
      for (int i = 0; i < 1000; i++)
         offer_pair(17'($urandom_range(130000, 131071)), 17'd1,
                    i == 999, 1'b0, '0, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d pairs and %0d run sums in both modes, %0d of them clamped,",
               pairs_sent, sums_checked, sums_clamped);
      $display("under three idling mixes and a %0d-cycle result hold-off.", HOLD_CYCLES);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // long result hold-off, counted here so the sender keeps running
   initial begin : rsp_holdoff
      wait (hold_go == 1'b1);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : rsp_check
      run_sum_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected result: divergence %h saturated %b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (rsp_tuser)
               sums_clamped++;
            if (rsp_tdata !== want.divergence) begin
               $error("divergence: expected %h, actual %h", want.divergence, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.saturated) begin
               $error("saturated: expected %b, actual %b", want.saturated, rsp_tuser);
               error_count++;
            end
         end
      end
      rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
